/* sv/modular_square_root_p3mod4_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the modular square root block
// Shared property forms, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_SQUARE_ROOT_P3MOD4_MACROS_SVH
`define MODULAR_SQUARE_ROOT_P3MOD4_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define MSR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define MSR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/msr_pkg.sv */
// ----------------------------------------------------------------------------
// Modular square root package
// Widths, result and operation codes, control/status structs and the
// modular add used by the bit-serial multiplier.
// ----------------------------------------------------------------------------
package msr_pkg;

    // Data width of the modulus, the value and the root.
    localparam int W     = 32;
    // Exponent (p >> 2) + 1 needs one bit less than the modulus.
    localparam int EXP_W = W - 1;
    // Bit counter of the serial multiplier.
    localparam int CNT_W = $clog2(W);

    // Result status codes.
    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_NOROOT = 2'd1;
    localparam logic [1:0] ST_BADMOD = 2'd2;

    // Multiplier operand selections.
    localparam logic [1:0] OP_REDUCE = 2'd0;  // 1 * n, reduces n mod p
    localparam logic [1:0] OP_RB     = 2'd1;  // r * base
    localparam logic [1:0] OP_BB     = 2'd2;  // base * base
    localparam logic [1:0] OP_XX     = 2'd3;  // r * r, the check

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       mul_start;
        logic [1:0] mul_op;
        logic       e_shift;
        logic       e_clr_lsb;
        logic       negate;
        logic       emit;
        logic [1:0] emit_status;
    } msr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mod_ok;
        logic mul_done;
        logic mul_busy;
        logic e_zero;
        logic e_lsb;
        logic prod_eq_n;
    } msr_sts_t;

    // (a + b) mod p for a, b < p.
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a,
                                             input logic [W-1:0] b,
                                             input logic [W-1:0] p);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[W-1:0];
    endfunction

endpackage

/* sv/modular_square_root_p3mod4.sv */
// ----------------------------------------------------------------------------
// Modular square root for a modulus p with p mod 4 equal to 3
// Returns x = n^((p+1)/4) mod p or p - x when its square gives n mod p, else a no-root status.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low; busy then stays
// high until the item is finished, but never rises for a modulus that is
// not 3 mod 4. Its one result is shown on root and status for a single
// cycle marked by done, and the receiver cannot stall it, so it must take
// the result in that cycle. With such a modulus the result follows in the
// cycle after start. Otherwise an item runs one modular product at a time
// on the single bit-serial multiplier: one reduction, one squaring per bit
// of (p >> 2) + 1 but its top bit, one multiply per set bit of it, and one
// or two check squarings. The user must write the modulus through
// modulus_wdata and modulus_we only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "modular_square_root_p3mod4_macros.svh"

module modular_square_root_p3mod4
    import msr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [W-1:0] value,
    input  logic         modulus_we,
    input  logic [W-1:0] modulus_wdata,
    output logic         done,
    output logic [W-1:0] root,
    output logic [1:0]   status
);

    msr_cmd_t cmd;
    msr_sts_t sts;

    msr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    msr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .modulus_we    (modulus_we),
        .modulus_wdata (modulus_wdata),
        .value         (value),
        .cmd           (cmd),
        .sts           (sts),
        .done          (done),
        .root          (root),
        .status        (status)
    );

    // Checks on the result channel and the item sequencing.
    `MSR_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while still busy")
    `MSR_ASSERT_NXT(a_accept_moves, start && !busy, busy || done, "item accepted but dropped")
    `MSR_ASSERT_IMP(a_status_code, done, status <= ST_BADMOD, "bad status code")
    `MSR_ASSERT_IMP(a_root_zero, done && status != ST_FOUND, root == '0, "stray nonzero root")
    `MSR_ASSERT_IMP(a_mul_free, cmd.mul_start, !sts.mul_busy, "multiplier started while busy")

endmodule

/* sv/msr_modmul.sv */
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a * b mod p by double-and-add over the bits of b, MSB first,
// one bit per clock. The product holds until the next start.
// ----------------------------------------------------------------------------
module msr_modmul
    import msr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] p,
    output logic         busy,
    output logic         done,
    output logic [W-1:0] prod
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     a_reg;
    logic [W-1:0]     b_reg;
    logic [W-1:0]     acc_reg;
    logic [W-1:0]     acc_dbl;
    logic [W-1:0]     acc_next;

    // One step: double the accumulator, then add a when the bit is set.
    always_comb
    begin
        acc_dbl  = add_mod(acc_reg, acc_reg, p);
        acc_next = b_reg[W-1] ? add_mod(acc_dbl, a_reg, p) : acc_dbl;
    end

    // Control: bit counter, busy and the done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and accumulator.
    always_ff @(posedge clk)
    begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* sv/msr_datapath.sv */
// ----------------------------------------------------------------------------
// Modular square root datapath
// Holds the modulus, the reduced value, base, running result and exponent,
// drives the shared multiplier and registers the result.
// ----------------------------------------------------------------------------
module msr_datapath
    import msr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         modulus_we,
    input  logic [W-1:0] modulus_wdata,
    input  logic [W-1:0] value,
    input  msr_cmd_t     cmd,
    output msr_sts_t     sts,
    output logic         done,
    output logic [W-1:0] root,
    output logic [1:0]   status
);

    logic [W-1:0]     p_reg;
    logic [W-1:0]     n_reg;
    logic [W-1:0]     base_reg;
    logic [W-1:0]     r_reg;
    logic [EXP_W-1:0] e_reg;
    logic [1:0]       op_reg;
    logic             done_reg;
    logic [W-1:0]     root_reg;
    logic [1:0]       status_reg;
    logic [W-1:0]     mul_a;
    logic [W-1:0]     mul_b;
    logic             mul_busy;
    logic             mul_done;
    logic [W-1:0]     mul_prod;

    // Modulus register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p_reg <= W'(3);
        end else if (modulus_we) begin
            p_reg <= modulus_wdata;
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        unique case (cmd.mul_op)
            OP_REDUCE: begin mul_a = W'(1);   mul_b = n_reg;    end
            OP_RB:     begin mul_a = r_reg;   mul_b = base_reg; end
            OP_BB:     begin mul_a = base_reg; mul_b = base_reg; end
            default:   begin mul_a = r_reg;   mul_b = r_reg;    end
        endcase
    end

    msr_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (p_reg),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Working registers: load, product write-back, exponent and negation.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start) begin
            op_reg <= cmd.mul_op;
        end
        if (cmd.load) begin
            n_reg <= value;
            r_reg <= W'(1);
            e_reg <= {1'b0, p_reg[W-1:2]} + EXP_W'(1);
        end else begin
            if (mul_done) begin
                unique case (op_reg)
                    OP_REDUCE: begin n_reg <= mul_prod; base_reg <= mul_prod; end
                    OP_RB:     r_reg    <= mul_prod;
                    OP_BB:     base_reg <= mul_prod;
                    default:   ;
                endcase
            end
            if (cmd.negate) begin
                r_reg <= (r_reg == '0) ? '0 : p_reg - r_reg;
            end
            if (cmd.e_shift) begin
                e_reg <= e_reg >> 1;
            end else if (cmd.e_clr_lsb) begin
                e_reg[0] <= 1'b0;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= cmd.emit;
        end
    end

    // Result payload: the root is zero unless one was found.
    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            status_reg <= cmd.emit_status;
            root_reg   <= (cmd.emit_status == ST_FOUND) ? r_reg : '0;
        end
    end

    // Status to the controller.
    always_comb
    begin
        sts.mod_ok    = (p_reg[1:0] == 2'b11);
        sts.mul_done  = mul_done;
        sts.mul_busy  = mul_busy;
        sts.e_zero    = (e_reg == '0);
        sts.e_lsb     = e_reg[0];
        sts.prod_eq_n = (mul_prod == n_reg);
    end

    assign done   = done_reg;
    assign root   = root_reg;
    assign status = status_reg;

endmodule

/* sv/msr_ctrl.sv */
// ----------------------------------------------------------------------------
// Modular square root controller
// Sequences reduction, square-and-multiply exponentiation and up to two
// root checks, one multiplier operation at a time.
// ----------------------------------------------------------------------------
module msr_ctrl
    import msr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  msr_sts_t sts,
    output msr_cmd_t cmd,
    output logic     busy
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RED_GO   = 4'd1;
    localparam logic [3:0] S_RED_WAIT = 4'd2;
    localparam logic [3:0] S_EXP_CHK  = 4'd3;
    localparam logic [3:0] S_MULR     = 4'd4;
    localparam logic [3:0] S_SQB      = 4'd5;
    localparam logic [3:0] S_CHK1     = 4'd6;
    localparam logic [3:0] S_CHK2_GO  = 4'd7;
    localparam logic [3:0] S_CHK2     = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.mul_op      = OP_REDUCE;
        cmd.emit_status = ST_FOUND;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    if (sts.mod_ok) begin
                        cmd.load   = 1'b1;
                        state_next = S_RED_GO;
                    end else begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_BADMOD;
                    end
                end
            end
            S_RED_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = OP_REDUCE;
                state_next    = S_RED_WAIT;
            end
            S_RED_WAIT: begin
                if (sts.mul_done) begin
                    state_next = S_EXP_CHK;
                end
            end
            // One exponent bit: multiply when set, square when even; start the first check once the exponent is zero.
            S_EXP_CHK: begin
                cmd.mul_start = 1'b1;
                if (sts.e_zero) begin
                    cmd.mul_op = OP_XX;
                    state_next = S_CHK1;
                end else if (sts.e_lsb) begin
                    cmd.mul_op = OP_RB;
                    state_next = S_MULR;
                end else begin
                    cmd.mul_op  = OP_BB;
                    cmd.e_shift = 1'b1;
                    state_next  = S_SQB;
                end
            end
            S_MULR: begin
                if (sts.mul_done) begin
                    cmd.e_clr_lsb = 1'b1;
                    state_next    = S_EXP_CHK;
                end
            end
            S_SQB: begin
                if (sts.mul_done) begin
                    state_next = S_EXP_CHK;
                end
            end
            // First check on x; on failure try p - x.
            S_CHK1: begin
                if (sts.mul_done) begin
                    if (sts.prod_eq_n) begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        cmd.negate = 1'b1;
                        state_next = S_CHK2_GO;
                    end
                end
            end
            S_CHK2_GO: begin
                cmd.mul_start = 1'b1;
                cmd.mul_op    = OP_XX;
                state_next    = S_CHK2;
            end
            S_CHK2: begin
                if (sts.mul_done) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = sts.prod_eq_n ? ST_FOUND : ST_NOROOT;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
